// ----- rtl/rfm_pkg.sv -----
package rfm_pkg;

    // Width of the wrapping tick counter
    localparam int COUNT_BITS = 16;

    // Width of the reference rate register and of the quotient
    localparam int RATE_BITS = 20;
    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(250000);

    // Width of the period field on the result word
    localparam int PERIOD_BITS = 16;

    // BCD digits needed to hold any quotient, and digits shown on the result
    localparam int BCD_DIGITS = 7;
    localparam int SHOWN_DIGITS = 5;
    localparam int BCD_BITS = 4 * BCD_DIGITS;

    // Step counter covers one quotient bit per cycle plus the finish step
    localparam int STEP_BITS = $clog2(RATE_BITS + 1);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(RATE_BITS);

    // Add three to every BCD digit of five or more, ahead of the left shift
    function automatic logic [BCD_BITS-1:0] bcd_adjust(input logic [BCD_BITS-1:0] bcd);
        logic [BCD_BITS-1:0] res;
        res = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
            begin
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/reciprocal_frequency_meter.sv -----
// Reciprocal frequency meter. Each accepted input word is one reference tick
// carrying the sampled level of the measured signal. A rising edge arms the
// meter and clears the tick counter; the next rising edge closes the period
// and yields one result word: the period in ticks, ref_rate / period, and the
// low five decimal digits of that quotient, with flags for a zero period and
// for quotients above 99999. The edge that closes a period does not rearm, so
// every other period is measured. Words that do not close a period are taken
// one per cycle. A closing word starts a restoring divider that produces one
// quotient bit per cycle, MSB first, straight into a shift-add-3 BCD
// converter; input is stalled through the 20 quotient bits and the hand-off
// to the output register, longer if the previous result is still held. The user
// must write ref_rate via cfg_we/cfg_data only while idle; it is not enforced.
module reciprocal_frequency_meter
    import rfm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [RATE_BITS-1:0]   cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   signal_level,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PERIOD_BITS-1:0] period_ticks,
    output logic [RATE_BITS-1:0]   freq_hz,
    output logic [3:0]             digit_ten_thousands,
    output logic [3:0]             digit_thousands,
    output logic [3:0]             digit_hundreds,
    output logic [3:0]             digit_tens,
    output logic [3:0]             digit_ones,
    output logic                   over_range,
    output logic                   divide_by_zero
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    state_t                  state_reg;
    logic [RATE_BITS-1:0]    ref_rate_reg;
    logic                    prev_level_reg;
    logic                    phase_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    logic [STEP_BITS-1:0]    step_reg;
    logic                    dz_reg;

    // Divider and converter datapath
    logic [COUNT_BITS-1:0]   rem_reg;
    logic [COUNT_BITS-1:0]   rem_next;
    logic [RATE_BITS-1:0]    dvd_reg;
    logic [RATE_BITS-1:0]    quo_reg;
    logic [BCD_BITS-1:0]     bcd_reg;
    logic [BCD_BITS-1:0]     bcd_adj;
    logic [COUNT_BITS:0]     trial;
    logic                    qbit;

    // Output word registers
    logic                    out_valid_reg;
    logic [PERIOD_BITS-1:0]  period_reg;
    logic [RATE_BITS-1:0]    freq_reg;
    logic [4*SHOWN_DIGITS-1:0] digits_reg;
    logic                    over_reg;
    logic                    dz_out_reg;

    logic                    in_take;
    logic                    rising;
    logic                    closing;
    logic                    out_free;
    logic                    handoff;
    logic [COUNT_BITS+PERIOD_BITS-1:0] count_ext;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign rising   = signal_level && !prev_level_reg;
    assign closing  = in_take && phase_reg && rising;
    assign out_free = !out_valid_reg || !out_stall;
    assign handoff  = (state_reg == ST_DIVIDE) && (step_reg == LAST_STEP) && out_free;

    assign count_next = count_reg + COUNT_BITS'(1);
    assign count_ext  = {{PERIOD_BITS{1'b0}}, count_reg};

    // One restoring division step; a zero divisor forces every quotient bit low
    assign trial    = {rem_reg, dvd_reg[RATE_BITS-1]};
    assign qbit     = !dz_reg && (trial >= {1'b0, count_reg});
    assign rem_next = qbit ? COUNT_BITS'(trial - {1'b0, count_reg})
                           : trial[COUNT_BITS-1:0];
    assign bcd_adj  = bcd_adjust(bcd_reg);

    // Control state, configuration and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ref_rate_reg   <= RATE_RESET;
            prev_level_reg <= 1'b1;
            phase_reg      <= 1'b0;
            count_reg      <= '0;
            step_reg       <= '0;
            dz_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            period_reg     <= '0;
            freq_reg       <= '0;
            digits_reg     <= '0;
            over_reg       <= 1'b0;
            dz_out_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ref_rate_reg <= cfg_data;
            end

            // Drop the output word once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && !handoff)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        prev_level_reg <= signal_level;
                        if (!phase_reg)
                        begin
                            // Arm on a rising edge
                            if (rising)
                            begin
                                phase_reg <= 1'b1;
                                count_reg <= '0;
                            end
                        end
                        else
                        begin
                            count_reg <= count_next;
                            if (rising)
                            begin
                                phase_reg <= 1'b0;
                                dz_reg    <= (count_next == '0);
                                step_reg  <= '0;
                                state_reg <= ST_DIVIDE;
                            end
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    if (step_reg != LAST_STEP)
                    begin
                        step_reg <= step_reg + STEP_BITS'(1);
                    end
                    else if (out_free)
                    begin
                        // Hand the finished word to the output register
                        out_valid_reg <= 1'b1;
                        period_reg    <= count_ext[PERIOD_BITS-1:0];
                        freq_reg      <= quo_reg;
                        digits_reg    <= bcd_reg[4*SHOWN_DIGITS-1:0];
                        over_reg      <= |bcd_reg[BCD_BITS-1:4*SHOWN_DIGITS];
                        dz_out_reg    <= dz_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Load and advance the divider and BCD shift registers
    always_ff @(posedge clk)
    begin
        if (closing)
        begin
            rem_reg <= '0;
            dvd_reg <= ref_rate_reg;
            quo_reg <= '0;
            bcd_reg <= '0;
        end
        else if (state_reg == ST_DIVIDE && step_reg != LAST_STEP)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[RATE_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[RATE_BITS-2:0], qbit};
            bcd_reg <= {bcd_adj[BCD_BITS-2:0], qbit};
        end
    end

    assign out_valid           = out_valid_reg;
    assign period_ticks        = period_reg;
    assign freq_hz             = freq_reg;
    assign digit_ten_thousands = digits_reg[19:16];
    assign digit_thousands     = digits_reg[15:12];
    assign digit_hundreds      = digits_reg[11:8];
    assign digit_tens          = digits_reg[7:4];
    assign digit_ones          = digits_reg[3:0];
    assign over_range          = over_reg;
    assign divide_by_zero      = dz_out_reg;

`ifndef ASSERT_OFF
    // A zero period gives an all-zero quotient and digits
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> freq_hz == '0 && digit_ones == 4'd0
            && digit_ten_thousands == 4'd0 && !over_range)
        else $error("divide by zero word carries a nonzero quotient");

    // The range flag agrees with the binary quotient
    a_over_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> over_range == (freq_hz > RATE_BITS'(99999)))
        else $error("over_range disagrees with freq_hz");

    // Every shown digit is a decimal digit
    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_ones <= 4'd9 && digit_tens <= 4'd9
            && digit_hundreds <= 4'd9 && digit_thousands <= 4'd9
            && digit_ten_thousands <= 4'd9)
        else $error("result digit out of decimal range");

    // A word that closes a period starts the divider at step zero
    a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
        closing |=> state_reg == ST_DIVIDE && step_reg == '0 && !phase_reg)
        else $error("closing edge did not start the divider");

    // The step counter never runs past the finish step
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> step_reg <= LAST_STEP)
        else $error("divider step counter overran");
`endif

endmodule

// ----- verif/reciprocal_frequency_meter_test.sv -----
module reciprocal_frequency_meter_test;
    import rfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 5;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DIGIT_SPAN = 100000;
    localparam int OVER_LIMIT = 99999;

    typedef struct {
        logic [PERIOD_BITS-1:0] period;
        logic [RATE_BITS-1:0]   freq;
        logic [3:0]             d_ten_thousands;
        logic [3:0]             d_thousands;
        logic [3:0]             d_hundreds;
        logic [3:0]             d_tens;
        logic [3:0]             d_ones;
        logic                   over;
        logic                   div_zero;
    } meter_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [RATE_BITS-1:0]   cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   signal_level;
    logic                   out_valid;
    logic                   out_stall;
    logic [PERIOD_BITS-1:0] period_ticks;
    logic [RATE_BITS-1:0]   freq_hz;
    logic [3:0]             digit_ten_thousands;
    logic [3:0]             digit_thousands;
    logic [3:0]             digit_hundreds;
    logic [3:0]             digit_tens;
    logic [3:0]             digit_ones;
    logic                   over_range;
    logic                   divide_by_zero;

    // Stimulus and expected results
    bit            level_queue[$];
    meter_result_t expected_results[$];
    int            words_queued;
    int            mismatches;
    int            cycle_count;
    bit            word_taken;
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_armed;
    bit            hold_started;
    int            hold_left;

    // Predictor state of the meter
    logic                  meter_prev_level;
    logic                  meter_armed;
    logic [COUNT_BITS-1:0] meter_ticks;
    logic [RATE_BITS-1:0]  meter_rate;

    reciprocal_frequency_meter dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .signal_level        (signal_level),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .period_ticks        (period_ticks),
        .freq_hz             (freq_hz),
        .digit_ten_thousands (digit_ten_thousands),
        .digit_thousands     (digit_thousands),
        .digit_hundreds      (digit_hundreds),
        .digit_tens          (digit_tens),
        .digit_ones          (digit_ones),
        .over_range          (over_range),
        .divide_by_zero      (divide_by_zero)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Advance the meter by one reference tick and queue any period result
    task automatic meter_tick(input logic level);
        meter_result_t res;
        logic          rising;
        int unsigned   quot;
        int unsigned   shown;
        rising = level && !meter_prev_level;
        meter_prev_level = level;
        if (!meter_armed)
        begin
            if (rising)
            begin
                meter_armed = 1'b1;
                meter_ticks = '0;
            end
        end
        else
        begin
            meter_ticks = meter_ticks + 1'b1;
            if (rising)
            begin
                res.div_zero = (meter_ticks == '0);
                quot = res.div_zero ? 0 : int'(meter_rate) / int'(meter_ticks);
                shown = quot % DIGIT_SPAN;
                res.period = PERIOD_BITS'(meter_ticks);
                res.freq = RATE_BITS'(quot);
                res.d_ten_thousands = 4'(shown / 10000);
                res.d_thousands = 4'((shown / 1000) % 10);
                res.d_hundreds = 4'((shown / 100) % 10);
                res.d_tens = 4'((shown / 10) % 10);
                res.d_ones = 4'(shown % 10);
                res.over = (quot > OVER_LIMIT);
                expected_results.push_back(res);
                meter_armed = 1'b0;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Take input words and feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            meter_tick(signal_level);
            word_taken = 1'b1;
        end
        else
        begin
            word_taken = 1'b0;
        end
    end

    // Drive the next level word, idling at random
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || word_taken))
        begin
            if (level_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                signal_level <= level_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_armed && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        meter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with no prediction pending");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("period_ticks", want.period, period_ticks);
                check_field("freq_hz", want.freq, freq_hz);
                check_field("digit_ten_thousands", want.d_ten_thousands,
                            digit_ten_thousands);
                check_field("digit_thousands", want.d_thousands, digit_thousands);
                check_field("digit_hundreds", want.d_hundreds, digit_hundreds);
                check_field("digit_tens", want.d_tens, digit_tens);
                check_field("digit_ones", want.d_ones, digit_ones);
                check_field("over_range", want.over, over_range);
                check_field("divide_by_zero", want.div_zero, divide_by_zero);
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_level(input bit level, input int count);
        repeat (count)
        begin
            level_queue.push_back(level);
            words_queued++;
        end
    endtask

    // One cycle of the measured signal: high then low
    task automatic queue_pulse(input int high_len, input int low_len);
        queue_level(1'b1, high_len);
        queue_level(1'b0, low_len);
    endtask

    function automatic int pick_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return $urandom_range(1, 6);
        else if (roll < 95)
            return $urandom_range(7, 40);
        return $urandom_range(41, 300);
    endfunction

    // Mostly clean pulse trains, some random glitches
    task automatic queue_random_words(input int count);
        int start;
        start = words_queued;
        while (words_queued - start < count)
        begin
            if ($urandom_range(99) < 85)
            begin
                queue_pulse(pick_len(), pick_len());
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                begin
                    queue_level(1'($urandom_range(1)), 1);
                end
            end
        end
    endtask

    // Wait until all words are taken and all results are back
    task automatic wait_drained();
        while (level_queue.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_BITS-1:0] rate);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= rate;
        @(negedge clk);
        cfg_we <= 1'b0;
        meter_rate = rate;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        signal_level = 1'b0;
        out_stall = 1'b0;
        words_queued = 0;
        mismatches = 0;
        cycle_count = 0;
        word_taken = 1'b0;
        hold_armed = 1'b0;
        hold_started = 1'b0;
        hold_left = 0;
        meter_prev_level = 1'b1;
        meter_armed = 1'b0;
        meter_ticks = '0;
        meter_rate = RATE_RESET;

        // Sender idles lightly, receiver heavily
        send_idle_pct = 24;
        recv_idle_pct = 59;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: leading high ignored, shortest period, mixed duty cycles
        queue_level(1'b1, 2);
        queue_level(1'b0, 1);
        queue_pulse(1, 1);
        queue_pulse(1, 1);
        queue_pulse(2, 3);
        queue_pulse(1, 1);
        queue_pulse(3, 4);
        queue_pulse(1, 2);
        queue_pulse(1, 2);
        queue_level(1'b1, 1);

        // Zero rate gives a zero quotient
        write_rate('0);
        queue_level(1'b0, 1);
        queue_pulse(1, 1);
        queue_pulse(1, 2);
        queue_pulse(2, 1);
        queue_pulse(1, 1);
        queue_level(1'b1, 1);

        write_rate({RATE_BITS{1'b1}});
        queue_random_words(300);
        write_rate(RATE_BITS'(200000));
        queue_random_words(60);
        write_rate(RATE_BITS'(199998));
        queue_random_words(60);

        // Sender idles heavily, receiver lightly
        wait_drained();
        send_idle_pct = 59;
        recv_idle_pct = 24;
        write_rate(RATE_BITS'(1));
        queue_random_words(150);
        write_rate(RATE_BITS'($urandom_range(1, (1 << RATE_BITS) - 1)));
        queue_random_words(170);

        // No idling; hold the result side off so the input backs up
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_rate(RATE_BITS'($urandom_range(1, (1 << RATE_BITS) - 1)));
        hold_armed = 1'b1;
        queue_random_words(210);

        wait_drained();
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
